FILE: hdl/stack_bytecode_execute_unit_defines.svh
// assertion macros for the stack execute unit
`ifndef STACK_BYTECODE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_BYTECODE_EXECUTE_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SBX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define SBX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/sbx_pkg.sv
`default_nettype none
package sbx_pkg;

    localparam int unsigned StackDepthDef = 1024;

    typedef enum logic [5:0] {
        OP_HLT = 6'd0, OP_NOP = 6'd1, OP_SYSCALL = 6'd2, OP_IPUSH = 6'd3,
        OP_IPUSH0 = 6'd4, OP_IPUSH1 = 6'd5, OP_IPUSH2 = 6'd6, OP_IPUSHM1 = 6'd7,
        OP_FPUSH0 = 6'd8, OP_FPUSH1 = 6'd9, OP_FPUSH2 = 6'd10, OP_FPUSH05 = 6'd11,
        OP_FPUSHM1 = 6'd12, OP_POP = 6'd13, OP_LDC = 6'd14, OP_IADD = 6'd15,
        OP_ISUB = 6'd16, OP_IMUL = 6'd17, OP_IPOW = 6'd18, OP_IADDO = 6'd19,
        OP_ISUBO = 6'd20, OP_IMULO = 6'd21, OP_IPOWO = 6'd22, OP_IDIV = 6'd23,
        OP_IMOD = 6'd24, OP_IAND = 6'd25, OP_IOR = 6'd26, OP_IXOR = 6'd27,
        OP_ISAL = 6'd28, OP_ISAR = 6'd29, OP_ISLR = 6'd30, OP_IROL = 6'd31,
        OP_IROR = 6'd32
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_HALT = 3'd1, ST_STKOV = 3'd2, ST_STKUN = 3'd3,
        ST_ARIOV = 3'd4, ST_ZDIV = 3'd5, ST_UNSUP = 3'd6, ST_IGN = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_WAIT, S_DONE
    } t_state;

    // operation handed to the multicycle arithmetic unit
    typedef enum logic [1:0] {
        AK_MUL, AK_POW, AK_DIV, AK_MOD
    } t_akind;

    typedef struct packed {
        logic        start;
        t_akind      kind;
        logic        checked;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [63:0] r;
    } t_alu_rsp;

    typedef struct packed {
        logic [5:0]         opcode;
        logic signed [23:0] immediate;
        logic signed [63:0] pool_word;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [63:0] top_value;
        logic [10:0]        stack_depth;
    } t_out;

endpackage
`default_nettype wire

FILE: hdl/stack_bytecode_execute_unit.sv
// push, pop and simple ops pass through memory read, execute and write back;
// multiply, divide, modulo and power wait on the shared arithmetic unit
// one request at a time: the next is taken only after the result is accepted
// reset: synchronous, clears depth, stop flag and control; stack data is not cleared
`default_nettype none
`include "stack_bytecode_execute_unit_defines.svh"
module stack_bytecode_execute_unit #(
    parameter int unsigned STACK_DEPTH = sbx_pkg::StackDepthDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire sbx_pkg::t_in i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output sbx_pkg::t_out    o_data
);
    import sbx_pkg::*;

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

    t_state      r_state, n_state;
    t_in         r_in;
    logic [DW-1:0] r_depth, n_depth;
    logic        r_stop, n_stop;
    logic [63:0] r_top, n_top;
    t_out        r_out, n_out;
    logic        r_ovalid, n_ovalid;
    logic        n_st_sel;

    logic        we;
    logic [AW-1:0] waddr, ra0, ra1;
    logic [63:0] wdata, rd0, rd1;
    t_alu_req    areq;
    t_alu_rsp    arsp;

    logic [63:0] a, b, imm64, pushv, simple_res, sum, dif;
    logic [5:0]  sh;
    logic [DW-1:0] dm1, dm2;
    logic        aov, sov;
    logic [2:0]  exec_st;
    logic        use_alu, want_wr;
    logic        negx;
    logic [63:0] negr;

    assign dm1 = r_depth - DW'(1);
    assign dm2 = r_depth - DW'(2);
    assign ra0 = dm2[AW-1:0];
    assign ra1 = dm1[AW-1:0];

    sbx_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr0(ra0), .i_raddr1(ra1), .o_rdata0(rd0), .o_rdata1(rd1)
    );

    sbx_arith u_arith (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(areq), .o_rsp(arsp));

    // operand and simple result path
    always_comb begin
        a = rd0;
        b = rd1;
        sh = b[5:0];
        imm64 = {{40{r_in.immediate[23]}}, r_in.immediate};
        sum = a + b;
        dif = a - b;
        aov = ((a ^ sum) & (b ^ sum) & 64'h8000_0000_0000_0000) != 64'd0;
        sov = ((a ^ b) & (a ^ dif) & 64'h8000_0000_0000_0000) != 64'd0;
        case (r_in.opcode)
            OP_IPUSH:   pushv = imm64;
            OP_IPUSH1:  pushv = 64'd1;
            OP_IPUSH2:  pushv = 64'd2;
            OP_IPUSHM1: pushv = '1;
            OP_FPUSH1:  pushv = 64'h3FF0_0000_0000_0000;
            OP_FPUSH2:  pushv = 64'h4000_0000_0000_0000;
            OP_FPUSH05: pushv = 64'h3FE0_0000_0000_0000;
            OP_FPUSHM1: pushv = 64'hBFF0_0000_0000_0000;
            OP_LDC:     pushv = r_in.pool_word;
            default:    pushv = 64'd0;
        endcase
        case (r_in.opcode)
            OP_IADD, OP_IADDO: simple_res = sum;
            OP_ISUB, OP_ISUBO: simple_res = dif;
            OP_IAND: simple_res = a & b;
            OP_IOR:  simple_res = a | b;
            OP_IXOR: simple_res = a ^ b;
            OP_ISAL: simple_res = a << sh;
            OP_ISAR: simple_res = $signed(a) >>> sh;
            OP_ISLR: simple_res = a >> sh;
            OP_IROL: simple_res = (a << sh) | (a >> (7'd64 - {1'b0, sh}));
            OP_IROR: simple_res = (a >> sh) | (a << (7'd64 - {1'b0, sh}));
            default: simple_res = 64'd0;
        endcase
        if (sh == 6'd0 && (r_in.opcode == OP_IROL || r_in.opcode == OP_IROR)) begin
            simple_res = a;
        end
        // negative exponent and zero exponent short cuts for power
        negx = 1'b0;
        negr = 64'd0;
        if (b == 64'd0) begin
            negx = 1'b1;
            negr = 64'd1;
        end else if (b[63]) begin
            negx = 1'b1;
            if (a == 64'd0) negr = 64'h7FFF_FFFF_FFFF_FFFF;
            else if (a == 64'd1) negr = 64'd1;
            else if (a == '1) negr = b[0] ? '1 : 64'd1;
            else negr = 64'd0;
        end
    end

    // control sequencer
    always_comb begin
        n_state = r_state;
        n_depth = r_depth;
        n_stop = r_stop;
        n_top = r_top;
        n_out = r_out;
        n_ovalid = r_ovalid;
        we = 1'b0;
        waddr = ra0;
        wdata = simple_res;
        areq = '0;
        areq.a = a;
        areq.b = b;
        n_st_sel = 1'b0;
        exec_st = ST_OK;
        use_alu = 1'b0;
        want_wr = 1'b0;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_READ;
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (r_stop) begin
                    exec_st = ST_IGN;
                end else if (r_in.opcode == OP_HLT) begin
                    exec_st = ST_HALT;
                end else if (r_in.opcode == OP_NOP) begin
                    exec_st = ST_OK;
                end else if (r_in.opcode == OP_POP) begin
                    if (r_depth == '0) exec_st = ST_STKUN;
                    else begin
                        n_depth = dm1;
                        n_top = a;
                    end
                end else if (r_in.opcode >= OP_IPUSH && r_in.opcode <= OP_LDC) begin
                    if (r_depth >= DW'(STACK_DEPTH)) exec_st = ST_STKOV;
                    else begin
                        we = 1'b1;
                        waddr = r_depth[AW-1:0];
                        wdata = pushv;
                        n_depth = r_depth + DW'(1);
                        n_top = pushv;
                    end
                end else if (r_in.opcode < OP_IADD || r_in.opcode > OP_IROR) begin
                    exec_st = ST_UNSUP;
                end else if (r_depth < DW'(2)) begin
                    exec_st = ST_STKUN;
                end else if ((r_in.opcode == OP_IDIV || r_in.opcode == OP_IMOD)
                             && b == 64'd0) begin
                    exec_st = ST_ZDIV;
                end else if ((r_in.opcode == OP_IDIV || r_in.opcode == OP_IMOD)
                             && a == 64'h8000_0000_0000_0000 && b == '1) begin
                    want_wr = 1'b1;
                    wdata = (r_in.opcode == OP_IDIV) ? a : 64'd0;
                end else if ((r_in.opcode == OP_IPOW || r_in.opcode == OP_IPOWO) && negx) begin
                    want_wr = 1'b1;
                    wdata = negr;
                end else if (r_in.opcode == OP_IMUL || r_in.opcode == OP_IMULO ||
                             r_in.opcode == OP_IPOW || r_in.opcode == OP_IPOWO ||
                             r_in.opcode == OP_IDIV || r_in.opcode == OP_IMOD) begin
                    use_alu = 1'b1;
                end else if (r_in.opcode == OP_IADD && aov) begin
                    exec_st = ST_ARIOV;
                end else if (r_in.opcode == OP_ISUB && sov) begin
                    exec_st = ST_ARIOV;
                end else begin
                    want_wr = 1'b1;
                end
                if (want_wr) begin
                    we = 1'b1;
                    waddr = ra0;
                    n_depth = dm1;
                    n_top = wdata;
                end
                if (use_alu) begin
                    areq.start = 1'b1;
                    areq.checked = (r_in.opcode == OP_IMUL || r_in.opcode == OP_IPOW);
                    case (r_in.opcode)
                        OP_IMUL, OP_IMULO: areq.kind = AK_MUL;
                        OP_IPOW, OP_IPOWO: areq.kind = AK_POW;
                        OP_IDIV: areq.kind = AK_DIV;
                        default: areq.kind = AK_MOD;
                    endcase
                    n_state = S_WAIT;
                end else begin
                    if (exec_st != ST_OK && exec_st != ST_IGN) n_stop = 1'b1;
                    n_out.status = exec_st;
                    n_out.top_value = (n_depth == '0) ? 64'd0 : n_top;
                    n_out.stack_depth = 11'(n_depth);
                    n_ovalid = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_WAIT: begin
                if (arsp.done) begin
                    n_st_sel = 1'b1;
                    if (arsp.ovf) begin
                        n_stop = 1'b1;
                        n_out.status = ST_ARIOV;
                        n_out.top_value = r_top;
                        n_out.stack_depth = 11'(r_depth);
                    end else begin
                        we = 1'b1;
                        waddr = ra0;
                        wdata = arsp.r;
                        n_depth = dm1;
                        n_top = arsp.r;
                        n_out.status = ST_OK;
                        n_out.top_value = arsp.r;
                        n_out.stack_depth = 11'(dm1);
                    end
                    n_ovalid = 1'b1;
                    n_state = S_DONE;
                end
            end
            default: begin
                if (!r_ovalid || i_ready) n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_stop <= 1'b0;
            r_ovalid <= 1'b0;
            r_top <= '0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_stop <= n_stop;
            r_ovalid <= n_ovalid;
            r_top <= n_top;
        end
        if (i_valid && o_ready) r_in <= i_data;
        r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_data = r_out;

    `SBX_ASSERT_IMP(a_depth_max, i_clk, i_rst_n, 1'b1, (r_depth <= DW'(STACK_DEPTH)))
    `SBX_ASSERT_NEXT(a_stop_sticks, i_clk, i_rst_n, r_stop, r_stop)
    `SBX_ASSERT_IMP(a_alu_wait, i_clk, i_rst_n, arsp.done, (r_state == S_WAIT) || n_st_sel)
endmodule
`default_nettype wire

FILE: hdl/sbx_stack_mem.sv
`default_nettype none
module sbx_stack_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [63:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr0,
    input  wire logic [AW-1:0] i_raddr1,
    output logic [63:0]        o_rdata0,
    output logic [63:0]        o_rdata1
);
    logic [63:0] mem [DEPTH];

    // one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= mem[i_raddr0];
        o_rdata1 <= mem[i_raddr1];
    end
endmodule
`default_nettype wire

FILE: hdl/sbx_arith.sv
`default_nettype none
`include "stack_bytecode_execute_unit_defines.svh"
module sbx_arith (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sbx_pkg::t_alu_req i_req,
    output sbx_pkg::t_alu_rsp  o_rsp
);
    import sbx_pkg::*;

    typedef enum logic [2:0] {
        A_IDLE, A_MUL, A_MULW, A_DIV, A_POW, A_PMUL, A_FIN
    } t_astate;

    localparam logic [63:0] SIGN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;

    t_astate     r_st, n_st;
    t_akind      r_kind;
    logic        r_chk;
    logic [63:0] r_a, r_b;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_base, n_base;
    logic [63:0] r_exp, n_exp;
    logic        r_ovf, n_ovf;
    logic [63:0] r_res, n_res;
    logic [6:0]  r_cnt, n_cnt;
    logic [1:0]  r_pc, n_pc;
    logic        r_phase, n_phase;
    // mul operands and partial products
    logic [63:0] r_mx, n_mx, r_my, n_my;
    logic        r_mneg, n_mneg;
    logic [127:0] r_prod, n_prod;
    logic [63:0] r_rem, n_rem, r_quo, n_quo, r_dv, n_dv;

    logic [31:0] px, py;
    logic [63:0] pp;
    logic [64:0] dsub;
    logic [127:0] ppw;
    logic [63:0] low64, lim;
    logic        mov;
    logic [63:0] signed_prod;

    // magnitudes of operands for multiplication and division
    function automatic logic [63:0] mag(input logic [63:0] v);
        mag = v[63] ? (64'd0 - v) : v;
    endfunction

    always_comb begin
        px = '0;
        py = '0;
        case (r_pc)
            2'd0: begin px = r_mx[31:0];  py = r_my[31:0];  end
            2'd1: begin px = r_mx[63:32]; py = r_my[31:0];  end
            2'd2: begin px = r_mx[31:0];  py = r_my[63:32]; end
            default: begin px = r_mx[63:32]; py = r_my[63:32]; end
        endcase
        pp = {32'd0, px} * {32'd0, py};
        case (r_pc)
            2'd0: ppw = {64'd0, pp};
            2'd1, 2'd2: ppw = {32'd0, pp, 32'd0};
            default: ppw = {pp, 64'd0};
        endcase
        low64 = r_prod[63:0];
        lim = r_mneg ? SIGN : SMAX;
        mov = (r_prod[127:64] != 64'd0) || (low64 > lim);
        signed_prod = r_mneg ? (64'd0 - low64) : low64;
        dsub = {r_rem[62:0], r_quo[63]} - {1'b0, r_dv};
    end

    // sequencer: multiply in four 32x32 partial products, divide one bit a cycle,
    // power by square and multiply reusing the multiplier
    always_comb begin
        n_st = r_st;
        n_acc = r_acc;
        n_base = r_base;
        n_exp = r_exp;
        n_ovf = r_ovf;
        n_res = r_res;
        n_cnt = r_cnt;
        n_pc = r_pc;
        n_phase = r_phase;
        n_mx = r_mx;
        n_my = r_my;
        n_mneg = r_mneg;
        n_prod = r_prod;
        n_rem = r_rem;
        n_quo = r_quo;
        n_dv = r_dv;
        case (r_st)
            A_IDLE: begin
                if (i_req.start) begin
                    n_ovf = 1'b0;
                    case (i_req.kind)
                        AK_MUL: begin
                            n_mx = mag(i_req.a);
                            n_my = mag(i_req.b);
                            n_mneg = i_req.a[63] ^ i_req.b[63];
                            n_prod = '0;
                            n_pc = 2'd0;
                            n_phase = 1'b0;
                            n_st = A_MUL;
                        end
                        AK_POW: begin
                            n_acc = 64'd1;
                            n_base = i_req.a;
                            n_exp = i_req.b;
                            n_phase = 1'b0;
                            n_st = A_POW;
                        end
                        default: begin
                            n_st = A_DIV;
                            n_cnt = 7'd0;
                            n_rem = '0;
                            n_quo = mag(i_req.a);
                            n_dv = mag(i_req.b);
                        end
                    endcase
                end
            end
            A_MUL, A_PMUL: begin
                n_prod = r_prod + ppw;
                n_pc = r_pc + 2'd1;
                if (r_pc == 2'd3) begin
                    n_st = (r_st == A_MUL) ? A_MULW : A_POW;
                    n_phase = (r_st == A_PMUL);
                end
            end
            A_MULW: begin
                n_res = signed_prod;
                n_ovf = mov;
                n_st = A_FIN;
            end
            A_DIV: begin
                if (!dsub[64]) begin
                    n_rem = dsub[63:0];
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = {r_rem[62:0], r_quo[63]};
                    n_quo = {r_quo[62:0], 1'b0};
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_st = A_FIN;
                end
            end
            A_POW: begin
                // r_phase set means a product just came back
                if (r_phase) begin
                    n_phase = 1'b0;
                    if (r_pc == 2'd0 && r_cnt[0] == 1'b0) begin
                        // acc * base result
                        n_acc = signed_prod;
                        if (r_chk && mov) n_ovf = 1'b1;
                        n_cnt[0] = 1'b1;
                        n_exp = {1'b0, r_exp[63:1]};
                    end else begin
                        n_base = signed_prod;
                        if (r_chk && mov) n_ovf = 1'b1;
                        n_cnt[0] = 1'b0;
                    end
                    if (r_chk && mov) n_st = A_FIN;
                end else if (r_cnt[0]) begin
                    // after possible multiply: square base if more bits remain
                    if (r_exp == 64'd0) begin
                        n_res = r_acc;
                        n_st = A_FIN;
                    end else begin
                        n_mx = mag(r_base);
                        n_my = mag(r_base);
                        n_mneg = 1'b0;
                        n_prod = '0;
                        n_pc = 2'd0;
                        n_cnt[1] = 1'b1;
                        n_st = A_PMUL;
                    end
                end else begin
                    if (r_exp == 64'd0) begin
                        n_res = r_acc;
                        n_st = A_FIN;
                    end else if (r_exp[0]) begin
                        n_mx = mag(r_acc);
                        n_my = mag(r_base);
                        n_mneg = r_acc[63] ^ r_base[63];
                        n_prod = '0;
                        n_pc = 2'd0;
                        n_cnt[1] = 1'b0;
                        n_st = A_PMUL;
                    end else begin
                        n_cnt[0] = 1'b1;
                        n_exp = {1'b0, r_exp[63:1]};
                    end
                end
            end
            default: begin
                n_st = A_IDLE;
            end
        endcase
        // distinguish acc product from square product on return
        if (r_st == A_POW && r_phase) begin
            if (!r_cnt[1]) begin
                n_acc = signed_prod;
                n_cnt[0] = 1'b1;
                n_exp = {1'b0, r_exp[63:1]};
            end else begin
                n_acc = r_acc;
                n_base = signed_prod;
                n_cnt[0] = 1'b0;
                n_exp = r_exp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
        end else begin
            r_st <= n_st;
        end
        if (r_st == A_IDLE && i_req.start) begin
            r_kind <= i_req.kind;
            r_chk <= i_req.checked;
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        r_acc <= n_acc;
        r_base <= n_base;
        r_exp <= n_exp;
        r_ovf <= n_ovf;
        r_res <= n_res;
        r_cnt <= (r_st == A_IDLE && i_req.start && i_req.kind == AK_POW) ? 7'd0 : n_cnt;
        r_pc <= n_pc;
        r_phase <= n_phase;
        r_mx <= n_mx;
        r_my <= n_my;
        r_mneg <= n_mneg;
        r_prod <= n_prod;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dv <= n_dv;
    end

    // final result, done and overflow, with sign fixes for division and modulo
    always_comb begin
        o_rsp.done = (r_st == A_FIN);
        o_rsp.ovf = r_ovf && r_chk;
        case (r_kind)
            AK_DIV: o_rsp.r = (r_a[63] ^ r_b[63]) ? (64'd0 - r_quo) : r_quo;
            AK_MOD: o_rsp.r = r_a[63] ? (64'd0 - r_rem) : r_rem;
            default: o_rsp.r = r_res;
        endcase
    end

    `SBX_ASSERT_IMP(a_idle_start, i_clk, i_rst_n, (r_st != A_IDLE), (r_st != A_IDLE) || 1'b1)
    `SBX_ASSERT_NEXT(a_fin_idle, i_clk, i_rst_n, (r_st == A_FIN), (r_st == A_IDLE))
    `SBX_ASSERT_IMP(a_div_cnt, i_clk, i_rst_n, (r_st == A_DIV), (r_cnt <= 7'd63))
    `SBX_ASSERT_IMP(a_pc_idle, i_clk, i_rst_n, (r_st == A_MULW), (r_pc == 2'd0))
endmodule
`default_nettype wire
